// ===== src/gsipid_pkg.sv =====
// Shared types, constants and gain tables of the gain-scheduled incremental PID.
`default_nettype none

package gsipid_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TARGET_SCALE = 2'd0;
  localparam logic [1:0] REG_OUT_UPPER    = 2'd1;
  localparam logic [1:0] REG_OUT_LOWER    = 2'd2;
  localparam logic [1:0] REG_SIGN_PRELOAD = 2'd3;

  // Configuration reset values
  localparam logic [15:0]       RST_TARGET_SCALE = 16'd256;
  localparam logic [9:0]        RST_OUT_UPPER    = 10'd599;
  localparam logic signed [10:0] RST_OUT_LOWER   = -11'sd599;
  localparam logic [9:0]        RST_SIGN_PRELOAD = 10'd265;

  localparam int unsigned DEF_CHANNELS = 2;

  // Datapath widths
  localparam int unsigned MUL_A_W = 26;  // error or target signed by its direction bit
  localparam int unsigned MUL_B_W = 19;  // Q6.12 coefficient or Q8.8 scale
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned INC_W   = PROD_W + 1;
  localparam int unsigned ACC_W   = 24;  // Q11.12 accumulator
  localparam int unsigned SUM_W   = 39;
  localparam int unsigned T_W     = 25;  // scaled target, Q.8
  localparam int unsigned DRV_W   = 10;

  // Band limits on |scaled target| in Q.8
  localparam logic [T_W-1:0] LIM_ZERO_GAIN = 25'd5120;
  localparam logic [T_W-1:0] LIM_BAND0     = 25'd2560;
  localparam logic [T_W-1:0] LIM_BAND1     = 25'd1792;
  localparam logic [T_W-1:0] LIM_BAND2     = 25'd1152;
  localparam logic [T_W-1:0] LIM_BAND3     = 25'd512;

  typedef enum logic [2:0] {
    BAND_0    = 3'd0,
    BAND_1    = 3'd1,
    BAND_2    = 3'd2,
    BAND_3    = 3'd3,
    BAND_4    = 3'd4,
    BAND_NONE = 3'd5
  } band_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2,
    SIGN_BAD  = 2'd3
  } sign_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_ERR,
    ST_MUL0,
    ST_MUL1,
    ST_ADD,
    ST_SUM,
    ST_CLAMP,
    ST_OUT
  } state_e;

  // A0 = Kp + Ki/400 in Q6.12
  function automatic logic signed [MUL_B_W-1:0] coef_a0(input band_e band);
    logic signed [MUL_B_W-1:0] c;
    unique case (band)
      BAND_0:  c = 19'sd24064;
      BAND_1:  c = 19'sd44544;
      BAND_2:  c = 19'sd84992;
      BAND_3:  c = 19'sd124928;
      BAND_4:  c = 19'sd144896;
      default: c = '0;
    endcase
    return c;
  endfunction

  // A1 = -Kp + Ki/400 in Q6.12
  function automatic logic signed [MUL_B_W-1:0] coef_a1(input band_e band);
    logic signed [MUL_B_W-1:0] c;
    unique case (band)
      BAND_0:  c = -19'sd16896;
      BAND_1:  c = -19'sd37376;
      BAND_2:  c = -19'sd78848;
      BAND_3:  c = -19'sd120832;
      BAND_4:  c = -19'sd141824;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/gain_scheduled_incremental_pid.sv =====
// Gain-scheduled incremental PID for two motors, built around one shared multiplier.
//
// Usage: one input transaction on s_axis carries both Q8.8 speed targets, the
// direction mask and both measured speeds. Each input transaction yields exactly
// one output transaction on m_axis with both clamped drive magnitudes and the
// sticky direction bits. Configuration is written through cfg_wr_en_i /
// cfg_idx_i / cfg_data_i while the block is idle; a write takes effect at once.
// Sequencing: a sequencer runs each channel through seven steps on
// the shared 26x19 multiplier and adder (scale target, form error, two
// coefficient products, sum, accumulate, clamp), and the result is loaded
// into the output register after the last channel. s_axis_tready goes
// high together with the result, so the next transaction can be accepted
// in that same cycle; a new item is not taken before the last one is done.
// The input side is not ready while an item is in work.
// The output register holds the last result; when the receiver stalls, the
// next item may still be accepted and computed, and it waits in the final
// step until the output register frees.
// Reset: accumulators, stored errors, sign codes and direction bits clear,
// the registers take their defaults, and no output is valid.
`default_nettype none

module gain_scheduled_incremental_pid #(
  parameter int unsigned CHANNELS = gsipid_pkg::DEF_CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // fields from bit 0: target_left[15:0], target_right[15:0], dir_mask[1:0],
  // measured_left[15:0], measured_right[15:0], zero fill
  input  wire logic [71:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // fields from bit 0: drive_left[9:0], drive_right[9:0], drive_dirs[1:0], zero fill
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import gsipid_pkg::*;

  localparam int unsigned NumAct = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int unsigned ChW    = (NumAct > 1) ? $clog2(NumAct) : 1;
  localparam logic [ChW-1:0] LastCh = ChW'(NumAct - 1);

  // Configuration registers
  logic [15:0]        scale_q;
  logic [9:0]         upper_q;
  logic signed [10:0] lower_q;
  logic [9:0]         preload_q;

  // Per-channel state
  logic signed [ACC_W-1:0]   acc_q  [NumAct];
  logic signed [MUL_A_W-1:0] el_q   [NumAct];
  sign_e                     sign_q [NumAct];
  logic [DRV_W-1:0]          drv_q  [NumAct];
  logic [1:0]                dir_q;

  // Sequencer and datapath registers
  state_e                    state_q, state_d;
  logic [ChW-1:0]            ch_q;
  logic [71:0]               in_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [MUL_A_W-1:0] e0_q;
  band_e                     band_q;
  sign_e                     code_q;
  logic signed [ACC_W-1:0]   base_q;
  logic signed [INC_W-1:0]   inc_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [23:0]               out_q;
  logic                      out_valid_q;

  logic                      accept;
  logic                      load_out;
  logic                      last_ch;

  // Per-channel input selection
  logic signed [15:0]        tgt_raw;
  logic signed [15:0]        meas;
  logic                      mask_bit;
  logic signed [16:0]        tgt_dir;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;

  // Error step
  logic signed [T_W-1:0]     t_val;
  logic [T_W-1:0]            t_mag;
  logic signed [MUL_A_W-1:0] e0_d;
  band_e                     band_d;
  sign_e                     code_d;

  // Preset and clamp
  logic signed [ACC_W-1:0]   pre_pos;
  logic signed [SUM_W-1:0]   upper_ext;
  logic signed [SUM_W-1:0]   lower_ext;
  logic signed [ACC_W-1:0]   acc_new;
  logic [ACC_W:0]            acc_abs;
  logic [DRV_W-1:0]          drv_new;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);
  assign last_ch  = (ch_q == LastCh);

  // Select the current channel's fields
  always_comb begin
    if (ch_q == '0) begin
      tgt_raw  = in_q[15:0];
      meas     = in_q[49:34];
      mask_bit = in_q[32];
    end else begin
      tgt_raw  = in_q[31:16];
      meas     = in_q[65:50];
      mask_bit = in_q[33];
    end
    tgt_dir = mask_bit ? 17'(tgt_raw) : -17'(tgt_raw);
  end

  // Route operands into the shared multiplier
  always_comb begin
    unique case (state_q)
      ST_MUL_T: begin
        mul_a = MUL_A_W'(tgt_dir);
        mul_b = {3'b000, scale_q};
      end
      ST_MUL0: begin
        mul_a = e0_q;
        mul_b = coef_a0(band_q);
      end
      ST_MUL1: begin
        mul_a = el_q[ch_q];
        mul_b = coef_a1(band_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Scale target, form error, pick band and sign
  always_comb begin
    t_val = prod_q[32:8];
    t_mag = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
    e0_d  = MUL_A_W'(t_val) - MUL_A_W'($signed({meas, 8'h00}));
    priority if (t_mag > LIM_ZERO_GAIN) band_d = BAND_NONE;
    else if (t_mag > LIM_BAND0)         band_d = BAND_0;
    else if (t_mag > LIM_BAND1)         band_d = BAND_1;
    else if (t_mag > LIM_BAND2)         band_d = BAND_2;
    else if (t_mag > LIM_BAND3)         band_d = BAND_3;
    else                                band_d = BAND_4;
    priority if (t_val[T_W-1]) code_d = SIGN_NEG;
    else if (t_val != '0)      code_d = SIGN_POS;
    else                       code_d = SIGN_ZERO;
  end

  // Clamp the new accumulator and derive the drive magnitude
  always_comb begin
    pre_pos   = ACC_W'({preload_q, 12'h000});
    upper_ext = SUM_W'({upper_q, 12'h000});
    lower_ext = SUM_W'($signed({lower_q, 12'h000}));
    priority if (code_q == SIGN_ZERO) acc_new = '0;
    else if (sum_q > upper_ext)       acc_new = ACC_W'(upper_ext);
    else if (sum_q < lower_ext)       acc_new = ACC_W'(lower_ext);
    else                              acc_new = ACC_W'(sum_q);
    acc_abs = acc_new[ACC_W-1] ? (ACC_W+1)'(-(ACC_W+1)'(acc_new)) : (ACC_W+1)'(acc_new);
    drv_new = (acc_abs[22]) ? {DRV_W{1'b1}} : acc_abs[21:12];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_MUL_T;
      ST_MUL_T: state_d = ST_ERR;
      ST_ERR:   state_d = ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_ADD;
      ST_ADD:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = last_ch ? ST_OUT : ST_MUL_T;
      ST_OUT:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= RST_TARGET_SCALE;
      upper_q   <= RST_OUT_UPPER;
      lower_q   <= RST_OUT_LOWER;
      preload_q <= RST_SIGN_PRELOAD;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_SCALE: scale_q   <= cfg_data_i;
        REG_OUT_UPPER:    upper_q   <= cfg_data_i[9:0];
        REG_OUT_LOWER:    lower_q   <= cfg_data_i[10:0];
        REG_SIGN_PRELOAD: preload_q <= cfg_data_i[9:0];
        default:          scale_q   <= scale_q;
      endcase
    end
  end

  // Advance the channel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (accept) begin
      ch_q <= '0;
    end else if (state_q == ST_CLAMP && !last_ch) begin
      ch_q <= ch_q + ChW'(1);
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= s_axis_tdata_i;
    end
    prod_q <= prod_d;
    if (state_q == ST_ERR) begin
      e0_q   <= e0_d;
      band_q <= band_d;
      code_q <= code_d;
    end
    if (state_q == ST_MUL0) begin
      if (sign_q[ch_q] != code_q) begin
        base_q <= (code_q == SIGN_NEG) ? -pre_pos : pre_pos;
      end else begin
        base_q <= acc_q[ch_q];
      end
    end
    if (state_q == ST_MUL1) begin
      inc_q <= INC_W'(prod_q);
    end
    if (state_q == ST_ADD) begin
      inc_q <= inc_q + INC_W'(prod_q);
    end
    if (state_q == ST_SUM) begin
      sum_q <= SUM_W'(base_q) + SUM_W'($signed(inc_q[INC_W-1:8]));
    end
    if (state_q == ST_CLAMP) begin
      drv_q[ch_q] <= drv_new;
    end
  end

  // Update per-channel loop state at the clamp step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAct; i++) begin
        acc_q[i]  <= '0;
        el_q[i]   <= '0;
        sign_q[i] <= SIGN_ZERO;
      end
      dir_q <= 2'b00;
    end else if (state_q == ST_CLAMP) begin
      acc_q[ch_q]  <= acc_new;
      el_q[ch_q]   <= e0_q;
      sign_q[ch_q] <= code_q;
      dir_q[ch_q]  <= !acc_new[ACC_W-1];
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= {2'b00, dir_q,
                (NumAct > 1) ? drv_q[NumAct-1] : {DRV_W{1'b0}},
                drv_q[0]};
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = out_valid_q;

  // On channel 0, a zero sign code always goes with a cleared accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sign_q[0] == SIGN_ZERO) |-> (acc_q[0] == '0))
    else $error("accumulator not cleared for zero target");

  // An accepted item blocks the input side on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while item in work");

  // A new result appears only from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside final step");

  // The sign code never takes the unused value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP) |-> (code_q != SIGN_BAD))
    else $error("invalid sign code");

endmodule

`default_nettype wire

// ===== bench/gain_scheduled_incremental_pid_tb.sv =====
// Self-checking bench for the two-channel gain-scheduled incremental PID block.
`default_nettype none

module gain_scheduled_incremental_pid_tb;
  import gsipid_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no transaction before giving up
  localparam int SQUEEZE_CYCLES = 300;

  // One input item; packed so that it drops straight onto tdata
  typedef struct packed {
    logic signed [15:0] meas_r;
    logic signed [15:0] meas_l;
    logic [1:0]         mask;
    logic signed [15:0] tgt_r;
    logic signed [15:0] tgt_l;
  } pid_in_t;

  // One result; same layout as m_axis_tdata_o[21:0]
  typedef struct packed {
    logic [1:0] dirs;
    logic [9:0] drv_r;
    logic [9:0] drv_l;
  } drive_t;

  // Directed row: input fields, then an optional hand-worked result
  typedef struct packed {
    logic signed [15:0] tl;
    logic signed [15:0] tr;
    logic [1:0]         mask;
    logic signed [15:0] ml;
    logic signed [15:0] mr;
    logic               lit;
    logic [9:0]         el;
    logic [9:0]         er;
    logic [1:0]         ed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [71:0] s_data = '0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_TARGET_SCALE;
  logic [15:0] cfg_data = '0;

  // Controller state and registers as the bench expects them
  logic [15:0]        model_scale = 16'd256;
  logic [9:0]         model_upper = 10'd599;
  logic signed [10:0] model_lower = -11'sd599;
  logic [9:0]         model_preload = 10'd265;
  longint             acc_q12 [2] = '{0, 0};
  longint             err_prev [2] = '{0, 0};
  sign_e              sign_prev [2] = '{SIGN_ZERO, SIGN_ZERO};
  logic [1:0]         dir_bits = 2'b00;

  drive_t drive_q [$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;
  bit     gaps_on = 1'b1;
  bit     squeeze_req = 1'b0;
  int     walk_tgt [2] = '{0, 0};
  logic [1:0] walk_mask = 2'b11;
  drive_t seen, want;

  row_t dir_rows [21] = '{
    '{0, 0, 0, 0, 0, 1, 0, 0, 3},
    '{32767, -32768, 3, 0, 0, 1, 265, 265, 1},
    '{32767, -32768, 3, 0, 0, 1, 265, 265, 1},
    '{32767, -32768, 0, 0, 0, 1, 265, 265, 2},
    '{-32768, 32767, 0, 32767, -32768, 1, 265, 265, 1},
    '{0, 0, 3, -32768, 32767, 1, 0, 0, 3},
    '{256, 256, 3, 1, 1, 0, 0, 0, 0},
    '{256, 256, 3, 0, 2, 0, 0, 0, 0},
    '{512, -512, 3, 0, 0, 0, 0, 0, 0},
    '{513, -513, 3, 1, -1, 0, 0, 0, 0},
    '{1152, 1153, 3, 3, 5, 0, 0, 0, 0},
    '{1792, 1793, 3, 7, 7, 0, 0, 0, 0},
    '{2560, 2561, 3, 10, 10, 0, 0, 0, 0},
    '{5120, 5121, 3, 20, 20, 0, 0, 0, 0},
    '{1, -1, 3, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0, 0},
    '{256, 256, 3, -32768, 32767, 0, 0, 0, 0},
    '{256, -256, 3, -32768, 32767, 0, 0, 0, 0},
    '{768, 768, 1, 100, -100, 0, 0, 0, 0},
    '{0, 300, 2, 5, 5, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 1, 0, 0, 3}
  };

  gain_scheduled_incremental_pid dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .cfg_wr_en_i     (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the controller state by one item and return both drives
  function automatic drive_t predict_drive(input pid_in_t it);
    drive_t             res;
    logic signed [15:0] t_in, m_in;
    longint             tgt, t, mag, e0, acc, a0, a1;
    band_e              band;
    sign_e              code;
    res = '0;
    for (int ch = 0; ch < 2; ch++) begin
      t_in = (ch == 0) ? it.tgt_l : it.tgt_r;
      m_in = (ch == 0) ? it.meas_l : it.meas_r;
      tgt = t_in;
      if (!it.mask[ch]) tgt = -tgt;
      t = (tgt * longint'(model_scale)) >>> 8;
      mag = (t < 0) ? -t : t;
      if (mag > 5120) band = BAND_NONE;
      else if (mag > 2560) band = BAND_0;
      else if (mag > 1792) band = BAND_1;
      else if (mag > 1152) band = BAND_2;
      else if (mag > 512) band = BAND_3;
      else band = BAND_4;
      case (band)
        BAND_0:  begin a0 = 24064;  a1 = -16896;  end
        BAND_1:  begin a0 = 44544;  a1 = -37376;  end
        BAND_2:  begin a0 = 84992;  a1 = -78848;  end
        BAND_3:  begin a0 = 124928; a1 = -120832; end
        BAND_4:  begin a0 = 144896; a1 = -141824; end
        default: begin a0 = 0;      a1 = 0;       end
      endcase
      code = (t > 0) ? SIGN_POS : ((t < 0) ? SIGN_NEG : SIGN_ZERO);
      e0 = t - longint'(m_in) * 256;

      acc = acc_q12[ch];
      if (code != SIGN_ZERO) begin
        // preset on a fresh or flipped target sign
        if (sign_prev[ch] == SIGN_ZERO || sign_prev[ch] == SIGN_BAD || sign_prev[ch] != code) begin
          acc = longint'(model_preload) * 4096;
          if (code == SIGN_NEG) acc = -acc;
        end
        acc = acc + ((a0 * e0 + a1 * err_prev[ch]) >>> 8);
        // upper limit is checked first, so it takes any value above it even when the limits cross
        if (acc > longint'(model_upper) * 4096) acc = longint'(model_upper) * 4096;
        else if (acc < longint'(model_lower) * 4096) acc = longint'(model_lower) * 4096;
      end else begin
        acc = 0;
      end
      sign_prev[ch] = code;
      err_prev[ch] = e0;
      acc_q12[ch] = acc;
      dir_bits[ch] = (acc >= 0);

      mag = ((acc < 0) ? -acc : acc) >>> 12;
      if (mag > 1023) mag = 1023;
      if (ch == 0) res.drv_l = 10'(mag);
      else res.drv_r = 10'(mag);
    end
    res.dirs = dir_bits;
    return res;
  endfunction

  // Draw an item: mostly steady targets with small errors, some raw noise
  function automatic pid_in_t next_item();
    pid_in_t it;
    int      mag, meas;
    it.tgt_l = 16'($urandom);
    it.tgt_r = 16'($urandom);
    it.mask = 2'($urandom);
    it.meas_l = 16'($urandom);
    it.meas_r = 16'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      for (int ch = 0; ch < 2; ch++) begin
        if ($urandom_range(0, 9) == 0) walk_mask[ch] = ~walk_mask[ch];
        case ($urandom_range(0, 15))
          0: walk_tgt[ch] = 0;
          1, 2: begin
            case ($urandom_range(0, 5))
              0: mag = int'($urandom_range(0, 520));
              1: mag = int'($urandom_range(500, 1160));
              2: mag = int'($urandom_range(1140, 1800));
              3: mag = int'($urandom_range(1780, 2570));
              4: mag = int'($urandom_range(2550, 5130));
              default: mag = int'($urandom_range(5100, 32767));
            endcase
            walk_tgt[ch] = $urandom_range(0, 1) ? -mag : mag;
          end
          default: walk_tgt[ch] = walk_tgt[ch] + int'($urandom_range(0, 64)) - 32;
        endcase
        if (walk_tgt[ch] > 32767) walk_tgt[ch] = 32767;
        if (walk_tgt[ch] < -32768) walk_tgt[ch] = -32768;
        meas = walk_tgt[ch] / 256 + int'($urandom_range(0, 16)) - 8;
        if (ch == 0) begin
          it.tgt_l = 16'(walk_tgt[ch]);
          it.meas_l = 16'(meas);
        end else begin
          it.tgt_r = 16'(walk_tgt[ch]);
          it.meas_r = 16'(meas);
        end
      end
      it.mask = walk_mask;
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then log what it should produce
  task automatic push_item(input pid_in_t it, input bit fixed, input drive_t fixed_exp);
    drive_t pred;
    int     gap;
    if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 18));
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data <= {6'd0, it};
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_drive(it);
    drive_q.push_back(fixed ? fixed_exp : pred);
    @(negedge clk_i);
  endtask

  // Stop offering and let every pending result come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive cycles
  task automatic load_cfg(input int scale, input int upper, input int lower, input int preload);
    cfg_we <= 1'b1;
    cfg_idx <= REG_TARGET_SCALE;
    cfg_data <= 16'(scale);
    @(negedge clk_i);
    cfg_idx <= REG_OUT_UPPER;
    cfg_data <= 16'(upper);
    @(negedge clk_i);
    cfg_idx <= REG_OUT_LOWER;
    cfg_data <= 16'(lower);
    @(negedge clk_i);
    cfg_idx <= REG_SIGN_PRELOAD;
    cfg_data <= 16'(preload);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    model_scale = 16'(scale);
    model_upper = 10'(upper);
    model_lower = 11'(lower);
    model_preload = 10'(preload);
  endtask

  // Pace the receiver: ready stretches, stall bursts and one long hold
  initial begin : sink_pacing
    int hold_cnt, go_cnt;
    hold_cnt = 0;
    go_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_cnt = SQUEEZE_CYCLES;
        go_cnt = 0;
      end
      if (hold_cnt > 0) begin
        m_ready <= 1'b0;
        hold_cnt--;
      end else if (calm || go_cnt > 0) begin
        m_ready <= 1'b1;
        if (go_cnt > 0) go_cnt--;
      end else if ($urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        hold_cnt = int'($urandom_range(1, 18)) - 1;
      end else begin
        m_ready <= 1'b1;
        go_cnt = int'($urandom_range(1, 60)) - 1;
      end
    end
  end

  // Compare each result transaction with the oldest pending expectation
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_ready) begin
      seen = m_axis_tdata_o[21:0];
      if (drive_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h", $time, seen);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        if (seen.drv_l !== want.drv_l) begin
          $display("%0t: drive_left expected %0d actual %0d", $time, want.drv_l, seen.drv_l);
          mismatches++;
        end
        if (seen.drv_r !== want.drv_r) begin
          $display("%0t: drive_right expected %0d actual %0d", $time, want.drv_r, seen.drv_r);
          mismatches++;
        end
        if (seen.dirs !== want.dirs) begin
          $display("%0t: drive_dirs expected %b actual %b", $time, want.dirs, seen.dirs);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    pid_in_t it;
    drive_t  lit_exp;
    int      count, lower;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows on reset settings
    foreach (dir_rows[r]) begin
      it.tgt_l = dir_rows[r].tl;
      it.tgt_r = dir_rows[r].tr;
      it.mask = dir_rows[r].mask;
      it.meas_l = dir_rows[r].ml;
      it.meas_r = dir_rows[r].mr;
      lit_exp.drv_l = dir_rows[r].el;
      lit_exp.drv_r = dir_rows[r].er;
      lit_exp.dirs = dir_rows[r].ed;
      push_item(it, dir_rows[r].lit, lit_exp);
    end

    // Random items, one register setting per phase
    for (int p = 0; p < 9; p++) begin
      count = 240;
      if (p > 0) wait_drained();
      case (p)
        0: count = 300;
        1: load_cfg(65535, 1023, -1024, 1023);
        2: begin
          load_cfg(0, 0, 0, 0);
          count = 60;
        end
        3: load_cfg(128, 50, 100, 10);
        4: begin
          load_cfg(1, 1023, -1023, 0);
          count = 150;
        end
        8: begin
          load_cfg(256, 599, -599, 265);
          count = 150;
          calm = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) lower = int'($urandom_range(0, 2047)) - 1024;
          else lower = -int'($urandom_range(0, 1023));
          load_cfg($urandom_range(0, 1) ? int'($urandom_range(64, 1024))
                                        : int'($urandom_range(0, 65535)),
                   int'($urandom_range(0, 1023)), lower, int'($urandom_range(0, 1023)));
        end
      endcase
      for (int n = 0; n < count; n++) begin
        if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (p == 0 && n == 100) squeeze_req = 1'b1;
        push_item(next_item(), 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/gsipid_pkg.sv
src/gain_scheduled_incremental_pid.sv
bench/gain_scheduled_incremental_pid_tb.sv
